### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// No dependencies; taken in by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hw/rtl/spq_pkg.sv
// Types and constants for the sorted priority queue.
// No dependencies; used by spq_cell and the top level.
package spq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int KEY_W        = 16;
    localparam int PAY_W        = 32;
    localparam int OCC_W        = 5;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_PUSH   = 2'd1,
        KIND_REMOVE = 2'd2
    } kind_e;

    typedef struct packed {
        logic [1:0]       kind;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } req_t;

    typedef struct packed {
        logic             item_valid;
        logic [KEY_W-1:0] out_key;
        logic [PAY_W-1:0] out_payload;
        logic             full_drop;
        logic [OCC_W-1:0] occupancy;
    } rsp_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } entry_t;

    typedef struct packed {
        logic   write_en;
        logic   push;
        logic   remove_en;
        entry_t ent;
    } cell_cmd_t;

endpackage

### hw/rtl/spq_cell.sv
// One storage cell of the queue row: holds one entry, shifts from its neighbors.
// Depends on spq_pkg.
module spq_cell (
    input  logic               clk,
    input  spq_pkg::cell_cmd_t cmd,
    input  logic               occ,
    input  spq_pkg::entry_t    left,
    input  spq_pkg::entry_t    right,
    input  logic               after_in,
    output logic               after_out,
    output spq_pkg::entry_t    entry
);
    import spq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   hit;

    // empty cells count as greater so the first free slot takes a tail insert
    assign hit       = cmd.push | ~occ | (entry_reg.key > cmd.ent.key);
    assign after_out = after_in | hit;
    assign entry     = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.write_en)
        begin
            if (after_in)
            begin
                entry_next = left;
            end
            else if (hit)
            begin
                entry_next = cmd.ent;
            end
        end
        else if (cmd.remove_en)
        begin
            entry_next = right;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

### hw/rtl/sorted_priority_queue_with_push_top.sv
// Sorted priority queue with head push, built as a row of CAPACITY shifting cells.
// The response register loads from each accepted request; one transaction per cycle while req_stall is low.
// The sorted insert position ripples through the cell row as a prefix flag.
// Input stalls only while a response is held and the output side stalls.
// Reset (rst_n, async low) empties the queue and drops any pending response.
module sorted_priority_queue_with_push_top #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  spq_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output spq_pkg::rsp_t rsp
);
    import spq_pkg::*;
    `include "assert_macros.svh"

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   rsp_valid_reg;
    rsp_t                   rsp_reg;
    rsp_t                   rsp_next;
    logic                   accept;
    logic                   full;
    logic                   empty;
    logic                   is_ins;
    logic                   is_push;
    logic                   is_rem;
    cell_cmd_t              cmd;
    logic [CAPACITY-1:0]    occ;
    logic [CAPACITY:0]      after;
    entry_t                 cells [CAPACITY];
    logic [CNT_W+OCC_W-1:0] cnt_ext;

    assign accept    = req_valid & ~req_stall;
    assign req_stall = rsp_valid_reg & rsp_stall;
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);

    always_comb
    begin
        is_ins  = 1'b0;
        is_push = 1'b0;
        is_rem  = 1'b0;
        unique case (req.kind)
            KIND_INSERT: is_ins  = 1'b1;
            KIND_PUSH:   is_push = 1'b1;
            KIND_REMOVE: is_rem  = 1'b1;
            default:     ;
        endcase
    end

    always_comb
    begin
        cmd.write_en  = accept & (is_ins | is_push) & ~full;
        cmd.push      = is_push;
        cmd.remove_en = accept & is_rem & ~empty;
        cmd.ent.key     = req.key;
        cmd.ent.payload = req.payload;
    end

    assign after[0] = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        entry_t left_ent;
        entry_t right_ent;

        assign occ[i] = (count_reg > CNT_W'(i));

        if (i == 0)
        begin : g_head
            assign left_ent = cmd.ent;
        end
        else
        begin : g_mid
            assign left_ent = cells[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_ent = cells[i];
        end
        else
        begin : g_body
            assign right_ent = cells[i+1];
        end

        spq_cell u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .occ       (occ[i]),
            .left      (left_ent),
            .right     (right_ent),
            .after_in  (after[i]),
            .after_out (after[i+1]),
            .entry     (cells[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.write_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.remove_en)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign cnt_ext = {{OCC_W{1'b0}}, count_next};

    always_comb
    begin
        rsp_next.item_valid  = cmd.remove_en;
        rsp_next.out_key     = cmd.remove_en ? cells[0].key : '0;
        rsp_next.out_payload = cmd.remove_en ? cells[0].payload : '0;
        rsp_next.full_drop   = (is_ins | is_push) & full;
        rsp_next.occupancy   = cnt_ext[OCC_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // an insert or push written while the queue is not full always lands in some cell of the row
    `ASSERT_SAME(a_insert_lands, clk, rst_n, cmd.write_en, after[CAPACITY])
    `ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(CAPACITY))
    `ASSERT_NEXT(a_remove_reports, clk, rst_n, cmd.remove_en, rsp_valid && rsp.item_valid)
    `ASSERT_NEXT(a_drop_keeps_count, clk, rst_n, accept && (is_ins || is_push) && full,
                 count_reg == $past(count_reg) && rsp.full_drop)

endmodule

### tb/sorted_priority_queue_with_push_top_tb.sv
// Self-checking testbench for sorted_priority_queue_with_push_top: directed and random traffic.
// Tracks the queue contents in a mirror class and checks every response transaction in order.
// Depends on spq_pkg and the top level RTL only.
class queue_mirror;
    logic [spq_pkg::KEY_W-1:0] keys [spq_pkg::CAPACITY_DEF];
    logic [spq_pkg::PAY_W-1:0] pays [spq_pkg::CAPACITY_DEF];
    int                        count;
    spq_pkg::rsp_t             pending_results [$];
    int                        mismatches;

    function new();
        count = 0;
        mismatches = 0;
    endfunction

    function void insert_at(int pos, logic [spq_pkg::KEY_W-1:0] k,
                            logic [spq_pkg::PAY_W-1:0] p);
        for (int i = count; i > pos; i--)
        begin
            keys[i] = keys[i-1];
            pays[i] = pays[i-1];
        end
        keys[pos] = k;
        pays[pos] = p;
        count++;
    endfunction

    function void apply_request(spq_pkg::req_t r);
        spq_pkg::rsp_t res;
        int pos;
        res = '0;
        if (r.kind == spq_pkg::KIND_INSERT || r.kind == spq_pkg::KIND_PUSH)
        begin
            if (count >= spq_pkg::CAPACITY_DEF)
                res.full_drop = 1'b1;
            else if (r.kind == spq_pkg::KIND_PUSH)
                insert_at(0, r.key, r.payload);
            else
            begin
                // head compared first, then scan from position 1 (contents may be unsorted)
                pos = 0;
                if (count > 0 && keys[0] <= r.key)
                begin
                    pos = 1;
                    while (pos < count && keys[pos] <= r.key)
                        pos++;
                end
                insert_at(pos, r.key, r.payload);
            end
        end
        else if (r.kind == spq_pkg::KIND_REMOVE && count > 0)
        begin
            res.item_valid = 1'b1;
            res.out_key = keys[0];
            res.out_payload = pays[0];
            for (int i = 1; i < count; i++)
            begin
                keys[i-1] = keys[i];
                pays[i-1] = pays[i];
            end
            count--;
        end
        res.occupancy = spq_pkg::OCC_W'(count);
        pending_results.push_back(res);
    endfunction

    function void check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
            mismatches++;
        end
    endfunction

    function void check_response(spq_pkg::rsp_t r);
        spq_pkg::rsp_t exp_r;
        if (pending_results.size() == 0)
        begin
            $error("response transaction with nothing outstanding");
            mismatches++;
            return;
        end
        exp_r = pending_results.pop_front();
        check_field("item_valid", 32'(exp_r.item_valid), 32'(r.item_valid));
        check_field("out_key", 32'(exp_r.out_key), 32'(r.out_key));
        check_field("out_payload", 32'(exp_r.out_payload), 32'(r.out_payload));
        check_field("full_drop", 32'(exp_r.full_drop), 32'(r.full_drop));
        check_field("occupancy", 32'(exp_r.occupancy), 32'(r.occupancy));
    endfunction
endclass

module sorted_priority_queue_with_push_top_tb;
    import spq_pkg::*;

    localparam logic [1:0] KIND_UNUSED   = 2'd3;
    localparam int         ITEMS_PER_RUN = 210;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    req_t        req;
    logic        rsp_valid;
    logic        rsp_stall;
    rsp_t        rsp;

    queue_mirror mirror;
    int          send_idle_pct;
    int          recv_idle_pct;

    sorted_priority_queue_with_push_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && req_valid && !req_stall)
            mirror.apply_request(req);
        if (rst_n && rsp_valid && !rsp_stall)
            mirror.check_response(rsp);
    end

    always @(negedge clk)
        rsp_stall <= rst_n && ($urandom_range(99) < recv_idle_pct);

    function automatic req_t make_req(logic [1:0] kind, logic [KEY_W-1:0] key,
                                      logic [PAY_W-1:0] payload);
        req_t r;
        r.kind = kind;
        r.key = key;
        r.payload = payload;
        return r;
    endfunction

    function automatic req_t random_request(int insert_pct);
        req_t r;
        int roll;
        roll = $urandom_range(99);
        if (roll < 3)
            r.kind = KIND_UNUSED;
        else if (roll < 3 + insert_pct)
            r.kind = ($urandom_range(9) < 7) ? KIND_INSERT : KIND_PUSH;
        else
            r.kind = KIND_REMOVE;
        case ($urandom_range(3))
            0: r.key = KEY_W'($urandom_range(7));
            1: r.key = $urandom_range(1) ? {KEY_W{1'b1}} : '0;
            default: r.key = KEY_W'($urandom);
        endcase
        r.payload = $urandom;
        return r;
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_item(req_t r);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (req_stall);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (mirror.pending_results.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    initial
    begin
        mirror = new();
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        rsp_stall = 1'b0;
        send_idle_pct = 20;
        recv_idle_pct = 75;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_item(make_req(KIND_REMOVE, 16'h1234, 32'h1234_5678));
        send_item(make_req(KIND_UNUSED, 16'h0000, 32'h0000_0000));
        send_item(make_req(KIND_INSERT, 16'h8000, 32'h0000_000A));
        send_item(make_req(KIND_INSERT, 16'h8000, 32'h0000_000B));
        send_item(make_req(KIND_INSERT, 16'h0000, 32'h0000_0000));
        send_item(make_req(KIND_INSERT, 16'hFFFF, 32'hFFFF_FFFF));
        send_item(make_req(KIND_PUSH, 16'hFFFF, 32'h5555_5555));
        send_item(make_req(KIND_INSERT, 16'h1234, 32'h0000_1234));
        send_item(make_req(KIND_PUSH, 16'h0000, 32'hAAAA_AAAA));
        send_item(make_req(KIND_INSERT, 16'h7FFF, 32'h0000_7FFF));
        send_item(make_req(KIND_UNUSED, 16'hFFFF, 32'hFFFF_FFFF));
        for (int i = 0; i < 8; i++)
            send_item(make_req(KIND_INSERT, KEY_W'(i * 16'h1111), $urandom));
        send_item(make_req(KIND_INSERT, 16'h0001, 32'hDEAD_0001));
        send_item(make_req(KIND_PUSH, 16'h0002, 32'hDEAD_0002));
        send_item(make_req(KIND_UNUSED, 16'h5A5A, 32'hA5A5_A5A5));
        send_item(make_req(KIND_REMOVE, 16'h0000, 32'h0000_0000));
        send_item(make_req(KIND_REMOVE, 16'hFFFF, 32'hFFFF_FFFF));
        wait_drained();

        for (int run = 0; run < 3; run++)
        begin
            send_idle_pct = (run == 0) ? 20 : (run == 1) ? 75 : 0;
            recv_idle_pct = (run == 0) ? 75 : (run == 1) ? 20 : 0;
            for (int n = 0; n < ITEMS_PER_RUN; n++)
            begin
                // alternate fill-heavy, drain-heavy and balanced stretches
                case ((n / 40) % 3)
                    0: send_item(random_request(72));
                    1: send_item(random_request(25));
                    default: send_item(random_request(48));
                endcase
            end
            wait_drained();
        end

        repeat (5) @(negedge clk);
        if (mirror.mismatches == 0 && mirror.pending_results.size() == 0)
            $display("sorted_priority_queue_with_push_top verification clean");
        else
            $display("sorted_priority_queue_with_push_top verification failed");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("sorted_priority_queue_with_push_top verification failed");
        $finish;
    end
endmodule
